@@ src/eadsr_pkg.sv @@
package eadsr_pkg;

    localparam int NUM_VOICES      = 16;
    localparam int SAMPLE_RATE_HZ  = 48000;
    localparam int RATE_TABLE_BITS = 10;

    localparam int VOICE_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CH_W      = 4;
    localparam int CH_COUNT  = 1 << CH_W;
    localparam int MV_W      = 15;
    localparam int KNOB_W    = 10;
    localparam int KNOB_SHIFT = 16 - KNOB_W;
    localparam int LEVEL_W   = 24;
    localparam int STATE_W   = LEVEL_W + 2;
    localparam int POS_W     = 17;
    localparam int COEF_W    = 25;
    localparam int TARGET_W  = 23;
    localparam int DIFF_W    = LEVEL_W + 2;
    localparam int MAG_W     = LEVEL_W + 1;
    localparam int PROD_W    = MAG_W + COEF_W;
    localparam int STEP_W    = PROD_W - 24;
    localparam int ENV_W     = 14;
    localparam int ENV_PROD_W = LEVEL_W + ENV_W;
    localparam int CFG_IDX_W = 2;

    localparam int ROM_SIZE  = (1 << RATE_TABLE_BITS) + 1;
    localparam int ROM_IDX_W = RATE_TABLE_BITS + 1;
    localparam int RATE_DEN  = SAMPLE_RATE_HZ * 256;

    localparam logic [KNOB_W-1:0]        KNOB_RESET    = 10'd512;
    localparam logic signed [MV_W-1:0]   GATE_ON_MV    = 15'sd1000;
    localparam logic signed [MV_W-1:0]   TRIG_OFF_MV   = 15'sd0;
    localparam logic [TARGET_W-1:0]      ATTACK_TARGET = 23'd5033165;
    localparam logic [LEVEL_W-1:0]       LEVEL_ONE     = 24'd4194304;
    localparam logic [LEVEL_W-1:0]       LEVEL_MAX     = 24'hFF_FFFF;
    localparam logic [POS_W-1:0]         POS_ONE       = 17'd65536;
    localparam logic [26:0]              CV_RECIP      = 27'd109951163;
    localparam int                       CV_SHIFT      = 24;
    localparam logic [PROD_W-1:0]        CEIL_BIAS     = 50'hFF_FFFF;
    localparam logic [ENV_W-1:0]         ENV_SCALE     = 14'd10000;
    localparam logic [ENV_PROD_W-1:0]    ENV_ROUND     = 38'd2097152;
    localparam logic [ENV_W-1:0]         ENV_MAX       = 14'd16383;

    localparam logic [31:0] POW_FACTOR [13] = '{
        32'd429497,     32'd42949673,   32'd429496730,  32'd1358187913,
        32'd2415237594, 32'd3220771102, 32'd3719288448, 32'd3996776483,
        32'd4143190098, 32'd4218396145, 32'd4256509543, 32'd4275695180,
        32'd4285320404
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK,
        CFG_DECAY,
        CFG_SUSTAIN,
        CFG_RELEASE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ATTACK,
        MODE_DECAY,
        MODE_RELEASE
    } t_mode;

    typedef logic [COEF_W-1:0]         t_coef;
    typedef t_coef [ROM_SIZE-1:0]      t_rate_rom;
    typedef logic [VOICE_W-1:0]        t_voice;
    typedef t_voice [CH_COUNT-1:0]     t_voice_map;

    function automatic t_rate_rom build_rate_rom();
        t_rate_rom   rom;
        logic [95:0] p;
        logic [95:0] c;
        for (int i = 0; i < ROM_SIZE; i++) begin
            p = 96'd1 << 32;
            for (int j = 0; j <= RATE_TABLE_BITS; j++) begin
                if (i[j]) begin
                    p = (p * 96'(POW_FACTOR[RATE_TABLE_BITS-j]) + 96'h8000_0000) >> 32;
                end
            end
            c = (p * 96'd1000 + 96'(RATE_DEN / 2)) / 96'(RATE_DEN);
            if (c > 96'd16777216) begin
                c = 96'd16777216;
            end
            rom[i] = COEF_W'(c);
        end
        return rom;
    endfunction

    function automatic t_voice_map build_voice_map();
        t_voice_map m;
        for (int i = 0; i < CH_COUNT; i++) begin
            m[i] = VOICE_W'(i % NUM_VOICES);
        end
        return m;
    endfunction

endpackage

@@ src/exponential_adsr_envelope.sv @@
// Exponential ADSR envelope for up to NUM_VOICES voices, one channel sample per transaction.
// Each voice keeps level, attack flag and trigger state in a state memory with one read and one
// write port, read as a transaction leaves stage P and written back as it leaves stage W. A
// result passes through stages P, Q, R, W and M and the output register, and the block takes
// one transaction per cycle while the output is not held back and no voice recurs within
// the three transactions before it; a transaction for a voice still in the read-modify-write
// window waits for its write-back. Channels beyond NUM_VOICES map onto voice channel modulo
// NUM_VOICES and are echoed unchanged. The user writes knob registers only while the block is
// idle; the block itself does not enforce this.
module exponential_adsr_envelope (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_cfg_we,
    input  logic [eadsr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [eadsr_pkg::KNOB_W-1:0]           i_cfg_data,

    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [eadsr_pkg::CH_W-1:0]             i_channel,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_gate_mv,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_trig_mv,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_attack_cv_mv,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_decay_cv_mv,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_sustain_cv_mv,
    input  logic signed [eadsr_pkg::MV_W-1:0]      i_release_cv_mv,

    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [eadsr_pkg::CH_W-1:0]             o_out_channel,
    output logic [eadsr_pkg::ENV_W-1:0]            o_envelope_mv
);

    localparam eadsr_pkg::t_voice_map VOICE_MAP = eadsr_pkg::build_voice_map();

    // knobs
    logic [eadsr_pkg::KNOB_W-1:0] r_attack_knob, r_decay_knob, r_sustain_knob, r_release_knob;

    // state memory
    logic [eadsr_pkg::STATE_W-1:0]    mem [eadsr_pkg::NUM_VOICES];
    logic [eadsr_pkg::NUM_VOICES-1:0] r_mem_vld;

    // stage P: input capture, positions
    logic                                 r_p_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_p_ch;
    logic signed [eadsr_pkg::MV_W-1:0]    r_p_gate_mv, r_p_trig_mv;
    logic signed [eadsr_pkg::MV_W-1:0]    r_p_cv_a, r_p_cv_d, r_p_cv_s, r_p_cv_r;
    logic [eadsr_pkg::VOICE_W-1:0]        p_voice;
    logic [eadsr_pkg::POS_W-1:0]          p_pos_a, p_pos_d, p_pos_s, p_pos_r;
    logic                                 p_hazard;

    // stage Q: state read, mode select, rate lookup
    logic                                 r_q_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_q_ch;
    logic [eadsr_pkg::VOICE_W-1:0]        r_q_voice;
    logic                                 r_q_gate, r_q_trig_on, r_q_trig_off;
    logic [eadsr_pkg::POS_W-1:0]          r_q_pos_a, r_q_pos_d, r_q_pos_s, r_q_pos_r;
    logic [eadsr_pkg::STATE_W-1:0]        r_q_rd;
    logic                                 r_q_rd_ok;
    logic [eadsr_pkg::LEVEL_W-1:0]        q_level;
    logic                                 q_flag, q_th, q_flag_t, q_th_new;
    eadsr_pkg::t_mode                     q_mode;
    logic [eadsr_pkg::POS_W-1:0]          q_pos;
    logic [eadsr_pkg::TARGET_W-1:0]       q_target;

    // stage R: multiply
    logic                                 r_r_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_r_ch;
    logic [eadsr_pkg::VOICE_W-1:0]        r_r_voice;
    logic                                 r_r_gate, r_r_flag, r_r_th;
    logic [eadsr_pkg::LEVEL_W-1:0]        r_r_level;
    logic [eadsr_pkg::TARGET_W-1:0]       r_r_target;
    logic [eadsr_pkg::COEF_W-1:0]         r_coef;
    logic signed [eadsr_pkg::DIFF_W-1:0]  r_diff;
    logic [eadsr_pkg::MAG_W-1:0]          r_mag;

    // stage W: level update, write-back
    logic                                 r_w_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_w_ch;
    logic [eadsr_pkg::VOICE_W-1:0]        r_w_voice;
    logic                                 r_w_gate, r_w_flag, r_w_th, r_w_neg;
    logic [eadsr_pkg::LEVEL_W-1:0]        r_w_level;
    logic [eadsr_pkg::PROD_W-1:0]         r_w_prod;
    logic [eadsr_pkg::STEP_W-1:0]         w_step;
    logic signed [eadsr_pkg::LEVEL_W+3:0] w_sum;
    logic [eadsr_pkg::LEVEL_W-1:0]        w_level;
    logic                                 w_flag;

    // stage M: millivolt scaling
    logic                                 r_m_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_m_ch;
    logic [eadsr_pkg::LEVEL_W-1:0]        r_m_level;
    logic [eadsr_pkg::ENV_PROD_W-1:0]     m_prod;
    logic [eadsr_pkg::ENV_W+1:0]          m_mv_wide;
    logic [eadsr_pkg::ENV_W-1:0]          m_mv;

    // output register
    logic                                 r_o_vld;
    logic [eadsr_pkg::CH_W-1:0]           r_o_ch;
    logic [eadsr_pkg::ENV_W-1:0]          r_o_mv;

    logic o_take, m_go, m_take, w_go, w_take, r_go, r_take, q_go, q_take, p_go, accept;

    always_comb begin
        o_take  = !r_o_vld || i_ready;
        m_go    = r_m_vld && o_take;
        m_take  = !r_m_vld || m_go;
        w_go    = r_w_vld && m_take;
        w_take  = !r_w_vld || w_go;
        r_go    = r_r_vld && w_take;
        r_take  = !r_r_vld || r_go;
        q_go    = r_q_vld && r_take;
        q_take  = !r_q_vld || q_go;
        p_go    = r_p_vld && q_take && !p_hazard;
        o_ready = !r_p_vld || p_go;
        accept  = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_knob  <= eadsr_pkg::KNOB_RESET;
            r_decay_knob   <= eadsr_pkg::KNOB_RESET;
            r_sustain_knob <= eadsr_pkg::KNOB_RESET;
            r_release_knob <= eadsr_pkg::KNOB_RESET;
        end else if (i_cfg_we) begin
            unique case (eadsr_pkg::t_cfg_idx'(i_cfg_idx))
                eadsr_pkg::CFG_ATTACK:  r_attack_knob  <= i_cfg_data;
                eadsr_pkg::CFG_DECAY:   r_decay_knob   <= i_cfg_data;
                eadsr_pkg::CFG_SUSTAIN: r_sustain_knob <= i_cfg_data;
                eadsr_pkg::CFG_RELEASE: r_release_knob <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_r_vld   <= 1'b0;
            r_w_vld   <= 1'b0;
            r_m_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
            r_mem_vld <= '0;
        end else begin
            if (o_ready) r_p_vld <= i_valid;
            if (q_take)  r_q_vld <= p_go;
            if (r_take)  r_r_vld <= q_go;
            if (w_take)  r_w_vld <= r_go;
            if (m_take)  r_m_vld <= w_go;
            if (o_take)  r_o_vld <= m_go;
            if (w_go)    r_mem_vld[r_w_voice] <= 1'b1;
        end
    end

    // stage P
    assign p_voice = VOICE_MAP[r_p_ch];

    eadsr_cv_pos u_pos_a (.i_knob(r_attack_knob),  .i_cv_mv(r_p_cv_a), .o_pos(p_pos_a));
    eadsr_cv_pos u_pos_d (.i_knob(r_decay_knob),   .i_cv_mv(r_p_cv_d), .o_pos(p_pos_d));
    eadsr_cv_pos u_pos_s (.i_knob(r_sustain_knob), .i_cv_mv(r_p_cv_s), .o_pos(p_pos_s));
    eadsr_cv_pos u_pos_r (.i_knob(r_release_knob), .i_cv_mv(r_p_cv_r), .o_pos(p_pos_r));

    // hold a voice until its pending write-back lands
    assign p_hazard = (r_q_vld && (r_q_voice == p_voice))
                   || (r_r_vld && (r_r_voice == p_voice))
                   || (r_w_vld && (r_w_voice == p_voice));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_ch      <= i_channel;
            r_p_gate_mv <= i_gate_mv;
            r_p_trig_mv <= i_trig_mv;
            r_p_cv_a    <= i_attack_cv_mv;
            r_p_cv_d    <= i_decay_cv_mv;
            r_p_cv_s    <= i_sustain_cv_mv;
            r_p_cv_r    <= i_release_cv_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_go) begin
            r_q_rd       <= mem[p_voice];
            r_q_rd_ok    <= r_mem_vld[p_voice];
            r_q_ch       <= r_p_ch;
            r_q_voice    <= p_voice;
            r_q_gate     <= r_p_gate_mv >= eadsr_pkg::GATE_ON_MV;
            r_q_trig_on  <= r_p_trig_mv >= eadsr_pkg::GATE_ON_MV;
            r_q_trig_off <= r_p_trig_mv <= eadsr_pkg::TRIG_OFF_MV;
            r_q_pos_a    <= p_pos_a;
            r_q_pos_d    <= p_pos_d;
            r_q_pos_s    <= p_pos_s;
            r_q_pos_r    <= p_pos_r;
        end
        if (w_go) begin
            mem[r_w_voice] <= {r_w_th, w_flag, w_level};
        end
    end

    // stage Q
    always_comb begin
        q_level  = r_q_rd_ok ? r_q_rd[eadsr_pkg::LEVEL_W-1:0] : '0;
        q_flag   = r_q_rd_ok && r_q_rd[eadsr_pkg::LEVEL_W];
        q_th     = r_q_rd_ok && r_q_rd[eadsr_pkg::LEVEL_W+1];
        q_flag_t = q_flag;
        q_th_new = q_th;
        if (r_q_trig_on) begin
            q_flag_t = q_flag || !q_th;
            q_th_new = 1'b1;
        end else if (r_q_trig_off) begin
            q_th_new = 1'b0;
        end
        if (r_q_gate && q_flag_t) begin
            q_mode = eadsr_pkg::MODE_ATTACK;
        end else if (r_q_gate) begin
            q_mode = eadsr_pkg::MODE_DECAY;
        end else begin
            q_mode = eadsr_pkg::MODE_RELEASE;
        end
    end

    always_comb begin
        unique case (q_mode)
            eadsr_pkg::MODE_ATTACK: begin
                q_pos    = r_q_pos_a;
                q_target = eadsr_pkg::ATTACK_TARGET;
            end
            eadsr_pkg::MODE_DECAY: begin
                q_pos    = r_q_pos_d;
                q_target = eadsr_pkg::TARGET_W'(r_q_pos_s) << 6;
            end
            default: begin
                q_pos    = r_q_pos_r;
                q_target = '0;
            end
        endcase
    end

    eadsr_rate_rom u_rate_rom (
        .i_clk  (i_clk),
        .i_en   (q_go),
        .i_idx  (q_pos[eadsr_pkg::POS_W-1 -: eadsr_pkg::ROM_IDX_W]),
        .o_coef (r_coef)
    );

    always_ff @(posedge i_clk) begin
        if (q_go) begin
            r_r_ch     <= r_q_ch;
            r_r_voice  <= r_q_voice;
            r_r_gate   <= r_q_gate;
            r_r_flag   <= q_flag_t;
            r_r_th     <= q_th_new;
            r_r_level  <= q_level;
            r_r_target <= q_target;
        end
    end

    // stage R
    always_comb begin
        r_diff = $signed(eadsr_pkg::DIFF_W'(r_r_target)) - $signed(eadsr_pkg::DIFF_W'(r_r_level));
        r_mag  = r_diff[eadsr_pkg::DIFF_W-1] ? eadsr_pkg::MAG_W'(-r_diff)
                                             : eadsr_pkg::MAG_W'(r_diff);
    end

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_w_ch    <= r_r_ch;
            r_w_voice <= r_r_voice;
            r_w_gate  <= r_r_gate;
            r_w_flag  <= r_r_flag;
            r_w_th    <= r_r_th;
            r_w_level <= r_r_level;
            r_w_neg   <= r_diff[eadsr_pkg::DIFF_W-1];
            r_w_prod  <= eadsr_pkg::PROD_W'(r_mag) * eadsr_pkg::PROD_W'(r_coef);
        end
    end

    // stage W
    always_comb begin
        if (r_w_neg) begin
            w_step = eadsr_pkg::STEP_W'((r_w_prod + eadsr_pkg::CEIL_BIAS) >> 24);
            w_sum  = $signed((eadsr_pkg::LEVEL_W+4)'(r_w_level))
                   - $signed((eadsr_pkg::LEVEL_W+4)'(w_step));
        end else begin
            w_step = eadsr_pkg::STEP_W'(r_w_prod >> 24);
            w_sum  = $signed((eadsr_pkg::LEVEL_W+4)'(r_w_level))
                   + $signed((eadsr_pkg::LEVEL_W+4)'(w_step));
        end
        if (w_sum < 0) begin
            w_level = '0;
        end else if (w_sum > $signed((eadsr_pkg::LEVEL_W+4)'(eadsr_pkg::LEVEL_MAX))) begin
            w_level = eadsr_pkg::LEVEL_MAX;
        end else begin
            w_level = eadsr_pkg::LEVEL_W'(w_sum);
        end
        w_flag = !r_w_gate || (r_w_flag && (w_level < eadsr_pkg::LEVEL_ONE));
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_m_ch    <= r_w_ch;
            r_m_level <= w_level;
        end
    end

    // stage M
    always_comb begin
        m_prod    = eadsr_pkg::ENV_PROD_W'(r_m_level) * eadsr_pkg::ENV_PROD_W'(eadsr_pkg::ENV_SCALE)
                  + eadsr_pkg::ENV_ROUND;
        m_mv_wide = (eadsr_pkg::ENV_W+2)'(m_prod >> 22);
        m_mv      = (m_mv_wide > (eadsr_pkg::ENV_W+2)'(eadsr_pkg::ENV_MAX))
                  ? eadsr_pkg::ENV_MAX : eadsr_pkg::ENV_W'(m_mv_wide);
    end

    always_ff @(posedge i_clk) begin
        if (m_go) begin
            r_o_ch <= r_m_ch;
            r_o_mv <= m_mv;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_out_channel = r_o_ch;
    assign o_envelope_mv = r_o_mv;

endmodule

@@ src/eadsr_cv_pos.sv @@
module eadsr_cv_pos (
    input  logic [eadsr_pkg::KNOB_W-1:0]      i_knob,
    input  logic signed [eadsr_pkg::MV_W-1:0] i_cv_mv,
    output logic [eadsr_pkg::POS_W-1:0]       o_pos
);

    logic [eadsr_pkg::MV_W-1:0]    cv_mag;
    logic [eadsr_pkg::MV_W+26:0]   cv_scaled;
    logic [eadsr_pkg::POS_W-1:0]   cv_step;
    logic [eadsr_pkg::POS_W+1:0]   knob_base;
    logic signed [eadsr_pkg::POS_W+1:0] pos_sum;

    always_comb begin
        cv_mag    = i_cv_mv[eadsr_pkg::MV_W-1] ? eadsr_pkg::MV_W'(-i_cv_mv)
                                               : eadsr_pkg::MV_W'(i_cv_mv);
        cv_scaled = (eadsr_pkg::MV_W+27)'(cv_mag) * (eadsr_pkg::MV_W+27)'(eadsr_pkg::CV_RECIP);
        cv_step   = eadsr_pkg::POS_W'(cv_scaled >> eadsr_pkg::CV_SHIFT);
        knob_base = (eadsr_pkg::POS_W+2)'(i_knob) << eadsr_pkg::KNOB_SHIFT;
        if (i_cv_mv[eadsr_pkg::MV_W-1]) begin
            pos_sum = $signed(knob_base) - $signed((eadsr_pkg::POS_W+2)'(cv_step));
        end else begin
            pos_sum = $signed(knob_base) + $signed((eadsr_pkg::POS_W+2)'(cv_step));
        end
        if (pos_sum < 0) begin
            o_pos = '0;
        end else if (pos_sum > $signed((eadsr_pkg::POS_W+2)'(eadsr_pkg::POS_ONE))) begin
            o_pos = eadsr_pkg::POS_ONE;
        end else begin
            o_pos = eadsr_pkg::POS_W'(pos_sum);
        end
    end

endmodule

@@ src/eadsr_rate_rom.sv @@
module eadsr_rate_rom (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [eadsr_pkg::ROM_IDX_W-1:0]  i_idx,
    output logic [eadsr_pkg::COEF_W-1:0]     o_coef
);

    localparam eadsr_pkg::t_rate_rom RATE_ROM = eadsr_pkg::build_rate_rom();

    logic [eadsr_pkg::COEF_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= RATE_ROM[i_idx];
        end
    end

    assign o_coef = r_coef;

endmodule

@@ tb/exponential_adsr_envelope_test.sv @@
module exponential_adsr_envelope_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 140;
    localparam int LONG_HOLD    = 60;
    localparam int TAIL_CYCLES  = 20;
    localparam int PRINT_LIMIT  = 40;

    localparam logic signed [eadsr_pkg::MV_W-1:0] TRIG_ON_MV = 15'sd1000;

    typedef struct {
        logic [eadsr_pkg::CH_W-1:0]        channel;
        logic signed [eadsr_pkg::MV_W-1:0] gate_mv, trig_mv;
        logic signed [eadsr_pkg::MV_W-1:0] attack_cv_mv, decay_cv_mv;
        logic signed [eadsr_pkg::MV_W-1:0] sustain_cv_mv, release_cv_mv;
    } t_sample;

    typedef struct {
        logic [eadsr_pkg::CH_W-1:0]  channel;
        logic [eadsr_pkg::ENV_W-1:0] envelope_mv;
    } t_envelope;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [eadsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [eadsr_pkg::KNOB_W-1:0]        i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic [eadsr_pkg::CH_W-1:0]          i_channel = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_gate_mv = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_trig_mv = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_attack_cv_mv = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_decay_cv_mv = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_sustain_cv_mv = '0;
    logic signed [eadsr_pkg::MV_W-1:0]   i_release_cv_mv = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [eadsr_pkg::CH_W-1:0]          o_out_channel;
    logic [eadsr_pkg::ENV_W-1:0]         o_envelope_mv;

    exponential_adsr_envelope dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_channel       (i_channel),
        .i_gate_mv       (i_gate_mv),
        .i_trig_mv       (i_trig_mv),
        .i_attack_cv_mv  (i_attack_cv_mv),
        .i_decay_cv_mv   (i_decay_cv_mv),
        .i_sustain_cv_mv (i_sustain_cv_mv),
        .i_release_cv_mv (i_release_cv_mv),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_channel   (o_out_channel),
        .o_envelope_mv   (o_envelope_mv)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_sample           pending_samples [$];
    t_envelope         envelope_expect [$];
    t_sample           offered;
    logic              sample_taken = 1'b0;
    int                send_gap = 0;
    int                ready_gap = 0;
    int                idle_pct = 0;
    logic              long_hold_req = 1'b0;
    int                long_hold_left = 0;

    int unsigned                   rate_table [eadsr_pkg::ROM_SIZE];
    logic [eadsr_pkg::LEVEL_W-1:0] voice_level [eadsr_pkg::NUM_VOICES];
    logic                          voice_attack [eadsr_pkg::NUM_VOICES];
    logic                          voice_trig_high [eadsr_pkg::NUM_VOICES];
    logic [eadsr_pkg::KNOB_W-1:0]  attack_knob = eadsr_pkg::KNOB_RESET;
    logic [eadsr_pkg::KNOB_W-1:0]  decay_knob = eadsr_pkg::KNOB_RESET;
    logic [eadsr_pkg::KNOB_W-1:0]  sustain_knob = eadsr_pkg::KNOB_RESET;
    logic [eadsr_pkg::KNOB_W-1:0]  release_knob = eadsr_pkg::KNOB_RESET;

    int                note_on_left [eadsr_pkg::CH_COUNT];
    int                note_off_left [eadsr_pkg::CH_COUNT];
    int                note_pool [3];

    int                cycle_count = 0;
    int                fail_count = 0;
    int                items_sent = 0;
    int                results_checked = 0;
    int                settings_run = 0;
    int                peak_count = 0;
    int                mode_count [3];

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    function automatic longint rate_position(logic [eadsr_pkg::KNOB_W-1:0] knob,
                                             logic signed [eadsr_pkg::MV_W-1:0] cv);
        longint x;
        x = (longint'(knob) << eadsr_pkg::KNOB_SHIFT) + (longint'(cv) * 65536) / 10000;
        if (x < 0) begin
            x = 0;
        end
        if (x > longint'(eadsr_pkg::POS_ONE)) begin
            x = longint'(eadsr_pkg::POS_ONE);
        end
        return x;
    endfunction

    function automatic longint rate_coef(logic [eadsr_pkg::KNOB_W-1:0] knob,
                                         logic signed [eadsr_pkg::MV_W-1:0] cv);
        return longint'(rate_table[rate_position(knob, cv)
                                   >> (16 - eadsr_pkg::RATE_TABLE_BITS)]);
    endfunction

    function automatic t_envelope predict_envelope(t_sample s);
        int               v;
        logic             gate;
        eadsr_pkg::t_mode mode;
        longint           target, coef, lev, diff, delta, mv;
        t_envelope        r;
        v = int'(s.channel) % eadsr_pkg::NUM_VOICES;
        gate = s.gate_mv >= eadsr_pkg::GATE_ON_MV;
        if (s.trig_mv >= TRIG_ON_MV) begin
            if (!voice_trig_high[v]) begin
                voice_attack[v] = 1'b1;
            end
            voice_trig_high[v] = 1'b1;
        end else if (s.trig_mv <= eadsr_pkg::TRIG_OFF_MV) begin
            voice_trig_high[v] = 1'b0;
        end
        if (gate && voice_attack[v]) begin
            mode = eadsr_pkg::MODE_ATTACK;
            target = longint'(eadsr_pkg::ATTACK_TARGET);
            coef = rate_coef(attack_knob, s.attack_cv_mv);
        end else if (gate) begin
            mode = eadsr_pkg::MODE_DECAY;
            target = rate_position(sustain_knob, s.sustain_cv_mv) << 6;
            coef = rate_coef(decay_knob, s.decay_cv_mv);
        end else begin
            mode = eadsr_pkg::MODE_RELEASE;
            target = 0;
            coef = rate_coef(release_knob, s.release_cv_mv);
        end
        mode_count[int'(mode)]++;
        lev = longint'(voice_level[v]);
        diff = target - lev;
        if (diff >= 0) begin
            delta = (diff * coef) >> 24;
        end else begin
            delta = -(((-diff) * coef + 64'hFF_FFFF) >> 24);
        end
        lev = lev + delta;
        if (lev < 0) begin
            lev = 0;
        end
        if (lev > longint'(eadsr_pkg::LEVEL_MAX)) begin
            lev = longint'(eadsr_pkg::LEVEL_MAX);
        end
        voice_level[v] = lev[eadsr_pkg::LEVEL_W-1:0];
        if (lev >= longint'(eadsr_pkg::LEVEL_ONE)) begin
            if (mode == eadsr_pkg::MODE_ATTACK) begin
                peak_count++;
            end
            voice_attack[v] = 1'b0;
        end
        if (!gate) begin
            voice_attack[v] = 1'b1;
        end
        mv = (lev * 10000 + 2097152) >> 22;
        if (mv > longint'(eadsr_pkg::ENV_MAX)) begin
            mv = longint'(eadsr_pkg::ENV_MAX);
        end
        r.channel = s.channel;
        r.envelope_mv = mv[eadsr_pkg::ENV_W-1:0];
        return r;
    endfunction

    task automatic queue_sample(int ch, int gate, int trig, int atk, int dec, int sus, int rel);
        t_sample s;
        s.channel = eadsr_pkg::CH_W'(ch);
        s.gate_mv = eadsr_pkg::MV_W'(gate);
        s.trig_mv = eadsr_pkg::MV_W'(trig);
        s.attack_cv_mv = eadsr_pkg::MV_W'(atk);
        s.decay_cv_mv = eadsr_pkg::MV_W'(dec);
        s.sustain_cv_mv = eadsr_pkg::MV_W'(sus);
        s.release_cv_mv = eadsr_pkg::MV_W'(rel);
        pending_samples.push_back(s);
    endtask

    function automatic int rand_mv();
        return int'($urandom_range(0, 24000)) - 12000;
    endfunction

    function automatic int quiet_trig();
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(1, 999));
        end
        return -int'($urandom_range(0, 12000));
    endfunction

    function automatic int fast_cv();
        if ($urandom_range(0, 4) != 0) begin
            return -int'($urandom_range(4000, 12000));
        end
        return rand_mv();
    endfunction

    // mostly note sequences on a small pool of voices, the rest is noise
    task automatic queue_notes(int count);
        int slot, c, gate, trig;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_sample($urandom_range(0, eadsr_pkg::CH_COUNT - 1), rand_mv(), rand_mv(),
                             rand_mv(), rand_mv(), rand_mv(), rand_mv());
            end else begin
                slot = $urandom_range(0, 2);
                c = note_pool[slot];
                trig = quiet_trig();
                if (note_on_left[c] == 0 && note_off_left[c] == 0) begin
                    note_on_left[c] = $urandom_range(0, 1) ? $urandom_range(8, 60)
                                                           : $urandom_range(90, 220);
                    note_off_left[c] = $urandom_range(2, 40);
                    trig = $urandom_range(1000, 12000);
                end else if (note_on_left[c] > 0 && $urandom_range(0, 39) == 0) begin
                    trig = $urandom_range(1000, 12000);
                end
                if (note_on_left[c] > 0) begin
                    gate = $urandom_range(1000, 12000);
                    note_on_left[c]--;
                end else begin
                    gate = $urandom_range(0, 1) ? -int'($urandom_range(0, 12000))
                                                : int'($urandom_range(0, 999));
                    note_off_left[c]--;
                    if (note_off_left[c] == 0 && $urandom_range(0, 3) == 0) begin
                        note_pool[slot] = $urandom_range(0, eadsr_pkg::CH_COUNT - 1);
                    end
                end
                queue_sample(c, gate, trig, fast_cv(), rand_mv(), rand_mv(),
                             $urandom_range(0, 1) ? fast_cv() : rand_mv());
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_samples.size() != 0 || i_valid || envelope_expect.size() != 0);
    endtask

    task automatic write_knob(eadsr_pkg::t_cfg_idx idx, logic [eadsr_pkg::KNOB_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            eadsr_pkg::CFG_ATTACK: attack_knob = val;
            eadsr_pkg::CFG_DECAY: decay_knob = val;
            eadsr_pkg::CFG_SUSTAIN: sustain_knob = val;
            eadsr_pkg::CFG_RELEASE: release_knob = val;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            envelope_expect.push_back(predict_envelope(offered));
            sample_taken = 1'b1;
            items_sent++;
        end
    end

    always @(negedge i_clk) begin : sample_driver
        logic offer;
        offer = i_valid && !sample_taken;
        sample_taken = 1'b0;
        if (!offer) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_samples.size() != 0) begin
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(0, 2);
                end else begin
                    offered = pending_samples.pop_front();
                    offer = 1'b1;
                end
            end
        end
        i_valid <= offer;
        if (offer) begin
            i_channel <= offered.channel;
            i_gate_mv <= offered.gate_mv;
            i_trig_mv <= offered.trig_mv;
            i_attack_cv_mv <= offered.attack_cv_mv;
            i_decay_cv_mv <= offered.decay_cv_mv;
            i_sustain_cv_mv <= offered.sustain_cv_mv;
            i_release_cv_mv <= offered.release_cv_mv;
        end
    end

    always @(negedge i_clk) begin : envelope_receiver
        logic take;
        take = 1'b1;
        if (long_hold_left > 0) begin
            long_hold_left--;
            take = 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            long_hold_left = LONG_HOLD - 1;
            take = 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            take = 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            ready_gap = $urandom_range(0, 2);
            take = 1'b0;
        end
        i_ready <= take;
    end

    always @(posedge i_clk) begin : envelope_monitor
        t_envelope want;
        if (i_rst_n && o_valid && i_ready) begin
            if (envelope_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, channel %0d, %0d mV",
                                          o_out_channel, o_envelope_mv));
            end else begin
                want = envelope_expect.pop_front();
                results_checked++;
                if (o_out_channel !== want.channel) begin
                    report_mismatch($sformatf("channel %0d, predicted %0d",
                                              o_out_channel, want.channel));
                end
                if (o_envelope_mv !== want.envelope_mv) begin
                    report_mismatch($sformatf("channel %0d: envelope %0d mV, predicted %0d mV",
                                              want.channel, o_envelope_mv, want.envelope_mv));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("exponential_adsr_envelope regression: fail");
            $finish;
        end
    end

    initial begin
        logic [95:0]                  prod, coefq;
        logic [eadsr_pkg::KNOB_W-1:0] plan [4];
        int                           idle_plan [PHASES];

        idle_plan = '{25, 0, 15, 30, 0};
        for (int i = 0; i < eadsr_pkg::ROM_SIZE; i++) begin
            prod = 96'd1 << 32;
            for (int j = 0; j <= eadsr_pkg::RATE_TABLE_BITS; j++) begin
                if (((i >> j) & 1) != 0) begin
                    prod = (prod * 96'(eadsr_pkg::POW_FACTOR[eadsr_pkg::RATE_TABLE_BITS - j])
                            + 96'h8000_0000) >> 32;
                end
            end
            coefq = (prod * 96'd1000 + 96'(eadsr_pkg::RATE_DEN / 2))
                  / 96'(eadsr_pkg::RATE_DEN);
            rate_table[i] = (coefq > 96'd16777216) ? 32'd16777216 : coefq[31:0];
        end
        for (int i = 0; i < eadsr_pkg::NUM_VOICES; i++) begin
            voice_level[i] = '0;
            voice_attack[i] = 1'b0;
            voice_trig_high[i] = 1'b0;
        end
        for (int i = 0; i < eadsr_pkg::CH_COUNT; i++) begin
            note_on_left[i] = 0;
            note_off_left[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            note_pool[i] = $urandom_range(0, eadsr_pkg::CH_COUNT - 1);
            mode_count[i] = 0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset knobs: field extremes, thresholds and trigger hysteresis
        idle_pct = 20;
        settings_run = 1;
        queue_sample(0, 12000, 12000, -12000, -12000, 12000, -12000);
        queue_sample(15, -12000, -12000, 12000, 12000, -12000, 12000);
        queue_sample(0, 1000, 999, -12000, 0, 0, 0);
        queue_sample(0, 999, 1, -12000, 0, 0, -12000);
        queue_sample(0, 1000, 0, -12000, 0, 0, 0);
        queue_sample(0, 1000, 1000, -12000, 0, 0, 0);
        queue_sample(0, 1000, 12000, -12000, 0, 0, 0);
        queue_sample(5, 0, 1000, 0, 0, 0, 0);
        queue_sample(5, 12000, 500, 0, 0, 0, 0);
        queue_sample(5, 12000, 0, -1, 1, -1, 1);
        queue_sample(9, 500, 500, 0, 0, 0, 0);
        queue_sample(9, 999, -1, 0, 0, 0, 0);
        queue_sample(7, 5000, 1000, -12000, -2000, 6000, -6000);
        queue_sample(7, 5000, 999, 12000, -12000, -12000, 12000);
        queue_sample(7, 5000, 0, -6000, -12000, 12000, 12000);
        queue_sample(7, -1, 0, 0, 0, 0, -12000);
        queue_sample(12, 12000, 12000, -12000, 12000, 12000, 0);
        queue_sample(12, 12000, -12000, -12000, -12000, 6000, 0);
        queue_sample(3, -12000, 12000, -12000, -12000, -12000, -12000);
        queue_sample(3, 12000, 1000, -5000, -5000, 5000, -5000);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: plan = '{10'd0, 10'd0, 10'd1023, 10'd0};
                1: plan = '{10'd1023, 10'd1023, 10'd0, 10'd1023};
                default: begin
                    for (int r = 0; r < 4; r++) begin
                        plan[r] = eadsr_pkg::KNOB_W'($urandom_range(0, 1023));
                    end
                end
            endcase
            write_knob(eadsr_pkg::CFG_ATTACK, plan[0]);
            write_knob(eadsr_pkg::CFG_DECAY, plan[1]);
            write_knob(eadsr_pkg::CFG_SUSTAIN, plan[2]);
            write_knob(eadsr_pkg::CFG_RELEASE, plan[3]);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            settings_run++;
            idle_pct = idle_plan[p];
            queue_notes(PHASE_ITEMS);
            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions under %0d knob settings, %0d envelopes checked",
                 items_sent, settings_run, results_checked);
        $display("attack/decay/release samples %0d/%0d/%0d, %0d attacks reached full scale",
                 mode_count[int'(eadsr_pkg::MODE_ATTACK)],
                 mode_count[int'(eadsr_pkg::MODE_DECAY)],
                 mode_count[int'(eadsr_pkg::MODE_RELEASE)], peak_count);
        if (fail_count == 0) begin
            $display("exponential_adsr_envelope regression: pass");
        end else begin
            $display("exponential_adsr_envelope regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/eadsr_pkg.sv
src/eadsr_cv_pos.sv
src/eadsr_rate_rom.sv
src/exponential_adsr_envelope.sv
tb/exponential_adsr_envelope_test.sv
